/* src/glob_name_filter_assert.svh */
// Assertion macros for the glob name filter
`ifndef GLOB_NAME_FILTER_ASSERT_SVH
`define GLOB_NAME_FILTER_ASSERT_SVH

// same-cycle implication
`define GNF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("glob_name_filter assertion failed");

// next-cycle implication
`define GNF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("glob_name_filter assertion failed");

`endif

/* src/gnf_pkg.sv */
// Shared types and constants for the glob name filter
`default_nettype none
package gnf_pkg;

  localparam int PatLen     = 32;
  localparam int PosW       = PatLen + 1;
  localparam int Levels     = $clog2(PosW);
  localparam int LenW       = 6;
  localparam int DepthLimit = 128;
  localparam int QDepth     = 2;

  localparam logic [7:0] StarByte = 8'h2A;
  localparam logic [7:0] AnyByte  = 8'h3F;

  localparam logic [1:0] KindFile = 2'd1;
  localparam logic [1:0] KindDir  = 2'd2;

  typedef enum logic [2:0] {
    RegPatA    = 3'd0,
    RegPatB    = 3'd1,
    RegPatC    = 3'd2,
    RegPatD    = 3'd3,
    RegPatLen  = 3'd4,
    RegLeast   = 3'd5,
    RegGreat   = 3'd6,
    RegKind    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [8*PatLen-1:0] pat;
    logic [LenW-1:0]     pat_len;
    logic [7:0]          least;
    logic [8:0]          greatest;
    logic [1:0]          kind;
  } cfg_t;

  typedef struct packed {
    logic       match;
    logic [7:0] depth;
    logic [1:0] kind;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* src/glob_name_filter.sv */
// Top level of the glob name filter
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   name_char, char_present, last_char,
//                                                entry_depth, entry_kind
//   out      output     out_valid_o/out_stall_i entry_matches
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One character per cycle unless the input stalls; the front end steps the
// 33-bit position vector through a log-depth star closure combinationally.
// A verdict passes through the queue and then the output register after its last character is taken.
// Reset restores register defaults and empties the two-entry queue.
// The input stalls only while the queue between front and back is full.
`default_nettype none
`include "glob_name_filter_assert.svh"
module glob_name_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  name_char_i,
  input  wire logic        char_present_i,
  input  wire logic        last_char_i,
  input  wire logic [7:0]  entry_depth_i,
  input  wire logic [1:0]  entry_kind_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             entry_matches_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  gnf_pkg::cfg_t      cfg_q, cfg_d;
  logic               cfg_wr;
  logic               push;
  logic               pop;
  gnf_pkg::item_t     push_item;
  gnf_pkg::item_t     pop_item;
  gnf_pkg::q_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (gnf_pkg::cfg_reg_e'(cfg_index_i))
        gnf_pkg::RegPatA:   cfg_d.pat[63:0]    = cfg_data_i;
        gnf_pkg::RegPatB:   cfg_d.pat[127:64]  = cfg_data_i;
        gnf_pkg::RegPatC:   cfg_d.pat[191:128] = cfg_data_i;
        gnf_pkg::RegPatD:   cfg_d.pat[255:192] = cfg_data_i;
        gnf_pkg::RegPatLen: cfg_d.pat_len      = cfg_data_i[5:0];
        gnf_pkg::RegLeast:  cfg_d.least        = cfg_data_i[7:0];
        gnf_pkg::RegGreat:  cfg_d.greatest     = cfg_data_i[8:0];
        gnf_pkg::RegKind:   cfg_d.kind         = cfg_data_i[1:0];
        default:            cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat      <= '0;
      cfg_q.pat_len  <= gnf_pkg::LenW'(1);
      cfg_q.least    <= '0;
      cfg_q.greatest <= '1;
      cfg_q.kind     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gnf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cfg_wr_i       (cfg_wr),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .name_char_i    (name_char_i),
    .char_present_i (char_present_i),
    .last_char_i    (last_char_i),
    .entry_depth_i  (entry_depth_i),
    .entry_kind_i   (entry_kind_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  gnf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  gnf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .item_i          (pop_item),
    .q_status_i      (q_status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .entry_matches_o (entry_matches_o)
  );

  `GNF_ASSERT_IMP(a_queue_sane, clk_i, rst_ni, 1'b1, !(q_status.full && q_status.empty))
  `GNF_ASSERT_NXT(a_push_fills, clk_i, rst_ni, push, !q_status.empty)
  `GNF_ASSERT_IMP(a_out_from_queue, clk_i, rst_ni, $rose(out_valid_o), $past(!q_status.empty))

endmodule
`default_nettype wire

/* src/gnf_front.sv */
// Front end: accepts name characters and steps the pattern position vector
`default_nettype none
module gnf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gnf_pkg::cfg_t     cfg_i,
  input  wire logic              cfg_wr_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        name_char_i,
  input  wire logic              char_present_i,
  input  wire logic              last_char_i,
  input  wire logic [7:0]        entry_depth_i,
  input  wire logic [1:0]        entry_kind_i,
  input  wire gnf_pkg::q_status_t q_status_i,
  output logic                   push_o,
  output gnf_pkg::item_t         push_item_o
);

  function automatic logic [gnf_pkg::PosW-1:0] closure(
    input logic [gnf_pkg::PosW-1:0] v,
    input logic [gnf_pkg::PatLen-1:0] s
  );
    logic [gnf_pkg::PosW-1:0] g;
    logic [gnf_pkg::PosW-1:0] p;
    logic [gnf_pkg::PosW-1:0] gn;
    logic [gnf_pkg::PosW-1:0] pn;
    g = v;
    p = {s, 1'b0};
    for (int l = 0; l < gnf_pkg::Levels; l++) begin
      gn = g;
      pn = p;
      for (int k = (1 << l); k < gnf_pkg::PosW; k++) begin
        gn[k] = g[k] | (p[k] & g[k - (1 << l)]);
        pn[k] = p[k] & p[k - (1 << l)];
      end
      g = gn;
      p = pn;
    end
    return g;
  endfunction

  logic [gnf_pkg::PosW-1:0]   active_q, active_d;
  logic                       fresh_q, fresh_d;
  logic [gnf_pkg::LenW-1:0]   used_len;
  logic [gnf_pkg::PatLen-1:0] is_star;
  logic [gnf_pkg::PatLen-1:0] is_adv;
  logic [gnf_pkg::PosW-1:0]   init_vec;
  logic [gnf_pkg::PosW-1:0]   cur;
  logic [gnf_pkg::PosW-1:0]   stepped;
  logic [gnf_pkg::PosW-1:0]   closed;
  logic                       accept;

  always_comb begin
    if (cfg_i.pat_len > gnf_pkg::LenW'(gnf_pkg::PatLen)) begin
      used_len = gnf_pkg::LenW'(gnf_pkg::PatLen);
    end else begin
      used_len = cfg_i.pat_len;
    end
  end

  always_comb begin
    for (int i = 0; i < gnf_pkg::PatLen; i++) begin
      is_star[i] = (gnf_pkg::LenW'(i) < used_len) &&
                   (cfg_i.pat[8*i +: 8] == gnf_pkg::StarByte);
      is_adv[i]  = (gnf_pkg::LenW'(i) < used_len) &&
                   (cfg_i.pat[8*i +: 8] != gnf_pkg::StarByte) &&
                   ((cfg_i.pat[8*i +: 8] == gnf_pkg::AnyByte) ||
                    (cfg_i.pat[8*i +: 8] == name_char_i));
    end
  end

  assign init_vec = closure({{(gnf_pkg::PosW-1){1'b0}}, 1'b1}, is_star);
  assign cur      = fresh_q ? init_vec : active_q;

  always_comb begin
    stepped = '0;
    for (int i = 0; i < gnf_pkg::PatLen; i++) begin
      stepped[i]   = stepped[i] | (cur[i] & is_star[i]);
      stepped[i+1] = cur[i] & is_adv[i];
    end
  end

  assign closed = closure(stepped, is_star);

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign push_o            = accept && last_char_i;
  assign push_item_o.match = char_present_i ? closed[used_len] : cur[used_len];
  assign push_item_o.depth = entry_depth_i;
  assign push_item_o.kind  = entry_kind_i;

  always_comb begin
    active_d = active_q;
    fresh_d  = fresh_q;
    if (cfg_wr_i) begin
      fresh_d = 1'b1;
    end else if (accept && last_char_i) begin
      fresh_d = 1'b1;
    end else if (accept && char_present_i) begin
      active_d = closed;
      fresh_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      fresh_q  <= 1'b1;
    end else begin
      active_q <= active_d;
      fresh_q  <= fresh_d;
    end
  end

endmodule
`default_nettype wire

/* src/gnf_queue.sv */
// Short queue between front end and back end
`default_nettype none
module gnf_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire gnf_pkg::item_t     push_item_i,
  input  wire logic               pop_i,
  output gnf_pkg::item_t          pop_item_o,
  output gnf_pkg::q_status_t      status_o
);

  localparam int PtrW = $clog2(gnf_pkg::QDepth);
  localparam int CntW = $clog2(gnf_pkg::QDepth + 1);

  gnf_pkg::item_t  slot_q [gnf_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CntW'(gnf_pkg::QDepth));
  assign status_o.empty = (count_q == '0);
  assign pop_item_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(gnf_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(gnf_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

/* src/gnf_back.sv */
// Back end: applies depth and kind filters and holds the verdict
`default_nettype none
module gnf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gnf_pkg::cfg_t      cfg_i,
  input  wire gnf_pkg::item_t     item_i,
  input  wire gnf_pkg::q_status_t q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    entry_matches_o
);

  logic out_valid_q, out_valid_d;
  logic matches_q, matches_d;
  logic depth_ok;
  logic kind_ok;
  logic verdict;

  always_comb begin
    depth_ok = (item_i.depth >= cfg_i.least) &&
               (cfg_i.greatest[8] || ({1'b0, item_i.depth} <= cfg_i.greatest)) &&
               (int'(item_i.depth) <= gnf_pkg::DepthLimit);
    if (cfg_i.kind == gnf_pkg::KindFile) begin
      kind_ok = (item_i.kind == gnf_pkg::KindFile);
    end else if (cfg_i.kind == gnf_pkg::KindDir) begin
      kind_ok = (item_i.kind == gnf_pkg::KindDir);
    end else begin
      kind_ok = 1'b1;
    end
    verdict = item_i.match && depth_ok && kind_ok;
  end

  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    matches_d   = matches_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      matches_d   = verdict;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matches_q <= matches_d;
  end

  assign out_valid_o     = out_valid_q;
  assign entry_matches_o = matches_q;

endmodule
`default_nettype wire
